@@ hdl/ulsts_pkg.sv @@
// Shared types, constants and saturating arithmetic for the unit lower
// triangular sparse solver. No dependencies; used by the top level and the bench.
`default_nettype none

package ulsts_pkg;

   // Widths fixed by the interface fields.
   localparam int ROW_BITS   = 12;
   localparam int FIELD_BITS = 32;
   localparam int ACC_BITS   = 64;

   // Defaults for the top-level parameters.
   localparam int MAX_ROWS_DEF      = 4096;
   localparam int VALUE_BITS_DEF    = 32;
   localparam int FRACTION_BITS_DEF = 16;

   // Reset value of the alpha register: 1.0 in Q16.16.
   localparam logic [FIELD_BITS-1:0] ALPHA_RESET = 32'h0001_0000;

   // Signed limits of the accumulator.
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   // One input item.
   typedef struct packed {
      logic [ROW_BITS-1:0]          row_index;
      logic [ROW_BITS-1:0]          col_index;
      logic signed [FIELD_BITS-1:0] entry_value;
      logic                         has_entry;
      logic signed [FIELD_BITS-1:0] rhs_value;
      logic                         row_end;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [ROW_BITS-1:0]          solved_row;
      logic signed [FIELD_BITS-1:0] solution_value;
      logic                         saturated;
   } rsp_type;

   // Saturating add; the top bit of the result is the overflow flag.
   function automatic logic [ACC_BITS:0] add_sat(input logic signed [ACC_BITS-1:0] a,
                                                 input logic signed [ACC_BITS-1:0] b);
      logic signed [ACC_BITS-1:0] s;
      logic                       o;
      logic signed [ACC_BITS-1:0] r;
      s = a + b;
      o = (a[ACC_BITS-1] == b[ACC_BITS-1]) && (s[ACC_BITS-1] != a[ACC_BITS-1]);
      r = o ? (a[ACC_BITS-1] ? ACC_MIN : ACC_MAX) : s;
      return {o, r};
   endfunction

   // Saturating subtract a - b; the top bit of the result is the overflow flag.
   function automatic logic [ACC_BITS:0] sub_sat(input logic signed [ACC_BITS-1:0] a,
                                                 input logic signed [ACC_BITS-1:0] b);
      logic signed [ACC_BITS-1:0] d;
      logic                       o;
      logic signed [ACC_BITS-1:0] r;
      d = a - b;
      o = (a[ACC_BITS-1] != b[ACC_BITS-1]) && (d[ACC_BITS-1] != a[ACC_BITS-1]);
      r = o ? (a[ACC_BITS-1] ? ACC_MIN : ACC_MAX) : d;
      return {o, r};
   endfunction

endpackage

`default_nettype wire

@@ hdl/ulsts_store.sv @@
// Solution store: single-port-write, single-port-read synchronous RAM with a
// registered read. No package dependencies.
`default_nettype none

module ulsts_store #(
   parameter int DEPTH     = 4096,
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while the read enable is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/unit_lower_sparse_tri_solve_top.sv @@
// Unit lower triangular sparse solver, top level: pipeline, accumulator and
// interlock. Depends on ulsts_pkg and ulsts_store.
//
//   port group   direction   handshake            payload
//   req_*        in          req_valid/req_stall  ulsts_pkg::req_type
//   rsp_*        out         rsp_valid/rsp_stall  ulsts_pkg::rsp_type
//   csr_*        in          csr_wr_en            alpha_scale (csr_wr_data)
//
// One item is taken per cycle while req_stall is low. A row's result reaches the
// output register once its last item has been transferred in and has passed
// through the steps store read, multiply, accumulate and finish. An item that
// reads the solution of a row still in the pipeline is held until that row has
// been written to the store; the hold grows while the result channel is stalled.
// Synchronous reset clears control state and the row accumulator and sets alpha to 1.0; nothing else.
// A stalled result holds its pipeline slot; items keep entering until a second
// result reaches the finishing stage.
`default_nettype none

module unit_lower_sparse_tri_solve_top #(
   parameter int MAX_ROWS      = ulsts_pkg::MAX_ROWS_DEF,
   parameter int VALUE_BITS    = ulsts_pkg::VALUE_BITS_DEF,
   parameter int FRACTION_BITS = ulsts_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ulsts_pkg::req_type                  req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ulsts_pkg::rsp_type                       rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [ulsts_pkg::FIELD_BITS-1:0]    csr_wr_data
);

   localparam int ADDR_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ACC       = ulsts_pkg::ACC_BITS;
   localparam int RB        = ulsts_pkg::ROW_BITS;
   localparam logic signed [ACC-1:0] VMAX =
      ACC'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC-1:0] VMIN = -VMAX - 1;

   // Configuration register.
   logic [ulsts_pkg::FIELD_BITS-1:0] alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ulsts_pkg::ALPHA_RESET;
      end else if (csr_wr_en) begin
         alpha_ff <= csr_wr_data;
      end
   end

   // Pipeline registers.
   logic                          s1_valid_ff;
   logic [RB-1:0]                 s1_row_ff;
   logic                          s1_acc_ff;
   logic                          s1_col_ok_ff;
   logic                          s1_last_ff;
   logic signed [VALUE_BITS-1:0]  s1_val_ff;
   logic signed [VALUE_BITS-1:0]  s1_rhs_ff;

   logic                          s2_valid_ff;
   logic [RB-1:0]                 s2_row_ff;
   logic                          s2_acc_ff;
   logic                          s2_last_ff;
   logic signed [ACC-1:0]         s2_prod_ff;
   logic signed [ACC-1:0]         s2_scaled_ff;

   logic signed [ACC-1:0]         row_sum_ff;
   logic                          row_ovf_ff;

   logic                          s3_valid_ff;
   logic [RB-1:0]                 s3_row_ff;
   logic signed [ACC-1:0]         s3_sum_ff;
   logic                          s3_ovf_ff;
   logic signed [ACC-1:0]         s3_scaled_ff;

   logic                          out_valid_ff;
   ulsts_pkg::rsp_type            out_data_ff;

   // Handshake, pipeline advance and read-after-write interlock.
   logic advance;
   logic in_acc;
   logic hazard;
   logic accept;

   assign advance = !(s3_valid_ff && out_valid_ff && rsp_stall);
   assign in_acc  = req_data.has_entry && (req_data.col_index < req_data.row_index);
   assign hazard  = in_acc &&
                    ((s1_valid_ff && s1_last_ff && (s1_row_ff == req_data.col_index)) ||
                     (s2_valid_ff && s2_last_ff && (s2_row_ff == req_data.col_index)) ||
                     (s3_valid_ff && (s3_row_ff == req_data.col_index)));
   assign req_stall = !advance || hazard;
   assign accept    = req_valid && !req_stall;

   // Solution store.
   logic [VALUE_BITS-1:0] store_rd_data;
   logic                  store_wr_en;
   logic signed [VALUE_BITS-1:0] fin_value;

   ulsts_store #(
      .DEPTH     (MAX_ROWS),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (VALUE_BITS)
   ) u_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (ADDR_BITS'(req_data.col_index)),
      .rd_data (store_rd_data),
      .wr_en   (store_wr_en),
      .wr_addr (ADDR_BITS'(s3_row_ff)),
      .wr_data (fin_value)
   );

   // Stage 1: capture the item while the store is read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff    <= req_data.row_index;
         s1_acc_ff    <= in_acc;
         s1_col_ok_ff <= 32'(req_data.col_index) < 32'(MAX_ROWS);
         s1_last_ff   <= req_data.row_end;
         s1_val_ff    <= req_data.entry_value[VALUE_BITS-1:0];
         s1_rhs_ff    <= req_data.rhs_value[VALUE_BITS-1:0];
      end
   end

   // Stage 2: product of the entry and the stored solution, and alpha times rhs.
   logic signed [VALUE_BITS-1:0]   x_in;
   logic signed [VALUE_BITS-1:0]   alpha_v;
   logic signed [2*VALUE_BITS-1:0] prod_in;
   logic signed [2*VALUE_BITS-1:0] scaled_in;

   assign x_in      = s1_col_ok_ff ? $signed(store_rd_data) : '0;
   assign alpha_v   = $signed(alpha_ff[VALUE_BITS-1:0]);
   assign prod_in   = s1_val_ff * x_in;
   assign scaled_in = alpha_v * s1_rhs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         s2_row_ff    <= s1_row_ff;
         s2_acc_ff    <= s1_acc_ff;
         s2_last_ff   <= s1_last_ff;
         s2_prod_ff   <= ACC'(prod_in);
         s2_scaled_ff <= ACC'(scaled_in);
      end
   end

   // Stage 3 entry: saturating accumulation; a row end hands the sum on and clears it.
   logic [ACC:0]          add_res;
   logic signed [ACC-1:0] sum_in;
   logic                  ovf_in;

   assign add_res = ulsts_pkg::add_sat(row_sum_ff, s2_prod_ff);
   assign sum_in  = s2_acc_ff ? $signed(add_res[ACC-1:0]) : row_sum_ff;
   assign ovf_in  = row_ovf_ff || (s2_acc_ff && add_res[ACC]);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff <= '0;
         row_ovf_ff <= 1'b0;
      end else if (advance && s2_valid_ff) begin
         if (s2_last_ff) begin
            row_sum_ff <= '0;
            row_ovf_ff <= 1'b0;
         end else begin
            row_sum_ff <= sum_in;
            row_ovf_ff <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff && s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff && s2_last_ff) begin
         s3_row_ff    <= s2_row_ff;
         s3_sum_ff    <= sum_in;
         s3_ovf_ff    <= ovf_in;
         s3_scaled_ff <= s2_scaled_ff;
      end
   end

   // Finish: subtract, floor shift and clamp to the value range.
   logic [ACC:0]          sub_res;
   logic signed [ACC-1:0] shifted;
   logic signed [ACC-1:0] clamped;
   logic                  fin_sat;

   assign sub_res = ulsts_pkg::sub_sat(s3_scaled_ff, s3_sum_ff);
   assign shifted = $signed(sub_res[ACC-1:0]) >>> FRACTION_BITS;

   always_comb begin
      priority if (shifted > VMAX) begin
         clamped = VMAX;
         fin_sat = 1'b1;
      end else if (shifted < VMIN) begin
         clamped = VMIN;
         fin_sat = 1'b1;
      end else begin
         clamped = shifted;
         fin_sat = 1'b0;
      end
   end

   assign fin_value   = clamped[VALUE_BITS-1:0];
   assign store_wr_en = s3_valid_ff && advance && (32'(s3_row_ff) < 32'(MAX_ROWS));

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s3_valid_ff && advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && advance) begin
         out_data_ff.solved_row     <= s3_row_ff;
         out_data_ff.solution_value <= ulsts_pkg::FIELD_BITS'(fin_value);
         out_data_ff.saturated      <= s3_ovf_ff || sub_res[ACC] || fin_sat;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   // A finished row moves into the output register with its own row index.
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && advance |=> rsp_valid && (rsp_data.solved_row == $past(s3_row_ff)))
      else $error("finished row did not reach the output register");

   // The accumulator is clear after a row end leaves the accumulation stage.
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_last_ff && advance |=> (row_sum_ff == '0) && !row_ovf_ff)
      else $error("row sum not cleared after row end");

   // An accepted item never reads a row whose store write is still to come.
   assert property (@(posedge clock) disable iff (reset)
      accept && in_acc |-> !(s3_valid_ff && (s3_row_ff == req_data.col_index)))
      else $error("store read overtook a pending write of the same row");
`endif

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for the unit lower triangular sparse solver top level.
// Depends on ulsts_pkg and the solver RTL; predicts each solved row in-bench.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PHASE_ITEMS   = 288;
   localparam int TIMEOUT_NS    = 5_000_000;
   localparam int LAST_ROW      = ulsts_pkg::MAX_ROWS_DEF - 1;

   localparam logic signed [ulsts_pkg::ACC_BITS-1:0] VAL_MAX = 64'sd2147483647;
   localparam logic signed [ulsts_pkg::ACC_BITS-1:0] VAL_MIN = -VAL_MAX - 64'sd1;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_stall;
   ulsts_pkg::req_type               req_data    = '0;
   logic                             rsp_valid;
   logic                             rsp_stall   = 1'b0;
   ulsts_pkg::rsp_type               rsp_data;
   logic                             csr_wr_en   = 1'b0;
   logic [ulsts_pkg::FIELD_BITS-1:0] csr_wr_data = '0;

   // Bench-side copy of the solver state.
   logic signed [ulsts_pkg::FIELD_BITS-1:0] x_store [ulsts_pkg::MAX_ROWS_DEF];
   bit                                      x_written [ulsts_pkg::MAX_ROWS_DEF];
   int                                      solved_rows [$];
   int                                      last_solved = -1;
   logic signed [ulsts_pkg::ACC_BITS-1:0]   running_sum = '0;
   logic                                    running_ovf = 1'b0;
   logic [ulsts_pkg::FIELD_BITS-1:0]        alpha_q     = ulsts_pkg::ALPHA_RESET;

   ulsts_pkg::rsp_type awaited_solutions [$];
   ulsts_pkg::rsp_type want;

   int errors            = 0;
   int sent_count        = 0;
   int sender_gap_pct    = 0;
   int receiver_hold_pct = 0;

   unit_lower_sparse_tri_solve_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #CLK_HALF clock = ~clock;

   // Random back-pressure on the result channel.
   always @(posedge clock) begin
      rsp_stall <= (receiver_hold_pct != 0) && ($urandom_range(99) < receiver_hold_pct);
   end

   // Compare every result transfer with the oldest awaited solution.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_solutions.size() == 0) begin
            $error("unexpected result for row %0d", rsp_data.solved_row);
            errors++;
         end else begin
            want = awaited_solutions.pop_front();
            if (rsp_data.solved_row !== want.solved_row) begin
               $error("solved_row: expected %0d, actual %0d",
                      want.solved_row, rsp_data.solved_row);
               errors++;
            end
            if (rsp_data.solution_value !== want.solution_value) begin
               $error("solution_value: expected %0d, actual %0d",
                      $signed(want.solution_value), $signed(rsp_data.solution_value));
               errors++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %0b, actual %0b",
                      want.saturated, rsp_data.saturated);
               errors++;
            end
         end
      end
   end

   // Advance the bench solver by one accepted item and queue any solved row.
   task automatic advance_solver(input ulsts_pkg::req_type item);
      logic signed [ulsts_pkg::ACC_BITS-1:0] product;
      logic signed [ulsts_pkg::ACC_BITS-1:0] scaled;
      logic signed [ulsts_pkg::ACC_BITS-1:0] diff;
      logic signed [ulsts_pkg::ACC_BITS-1:0] shifted;
      logic [ulsts_pkg::ACC_BITS:0]          wide;
      logic                                  sat;
      ulsts_pkg::rsp_type                    sol;
      if (item.has_entry && item.col_index < item.row_index) begin
         product = $signed(item.entry_value) * x_store[item.col_index];
         wide = {running_sum[ulsts_pkg::ACC_BITS-1], running_sum} +
                {product[ulsts_pkg::ACC_BITS-1], product};
         if (wide[ulsts_pkg::ACC_BITS] != wide[ulsts_pkg::ACC_BITS-1]) begin
            running_sum = wide[ulsts_pkg::ACC_BITS] ? ulsts_pkg::ACC_MIN : ulsts_pkg::ACC_MAX;
            running_ovf = 1'b1;
         end else begin
            running_sum = wide[ulsts_pkg::ACC_BITS-1:0];
         end
      end
      if (item.row_end) begin
         sat = running_ovf;
         scaled = $signed(alpha_q) * $signed(item.rhs_value);
         wide = {scaled[ulsts_pkg::ACC_BITS-1], scaled} -
                {running_sum[ulsts_pkg::ACC_BITS-1], running_sum};
         if (wide[ulsts_pkg::ACC_BITS] != wide[ulsts_pkg::ACC_BITS-1]) begin
            diff = wide[ulsts_pkg::ACC_BITS] ? ulsts_pkg::ACC_MIN : ulsts_pkg::ACC_MAX;
            sat = 1'b1;
         end else begin
            diff = wide[ulsts_pkg::ACC_BITS-1:0];
         end
         // Arithmetic shift rounds toward minus infinity.
         shifted = diff >>> ulsts_pkg::FRACTION_BITS_DEF;
         if (shifted > VAL_MAX) begin
            shifted = VAL_MAX;
            sat = 1'b1;
         end else if (shifted < VAL_MIN) begin
            shifted = VAL_MIN;
            sat = 1'b1;
         end
         sol.solved_row     = item.row_index;
         sol.solution_value = shifted[ulsts_pkg::FIELD_BITS-1:0];
         sol.saturated      = sat;
         awaited_solutions.push_back(sol);
         x_store[item.row_index] = shifted[ulsts_pkg::FIELD_BITS-1:0];
         if (!x_written[item.row_index]) begin
            x_written[item.row_index] = 1'b1;
            solved_rows.push_back(int'(item.row_index));
         end
         last_solved = int'(item.row_index);
         running_sum = '0;
         running_ovf = 1'b0;
      end
   endtask

   // Present one item, hold it until the transfer, then update the prediction.
   task automatic send_item(input ulsts_pkg::req_type item);
      if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_gap_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      advance_solver(item);
   endtask

   task automatic send_fields(input int row, input int col, input logic [31:0] val,
                              input logic has, input logic [31:0] rhs, input logic last);
      ulsts_pkg::req_type item;
      item.row_index   = ulsts_pkg::ROW_BITS'(row);
      item.col_index   = ulsts_pkg::ROW_BITS'(col);
      item.entry_value = val;
      item.has_entry   = has;
      item.rhs_value   = rhs;
      item.row_end     = last;
      send_item(item);
   endtask

   // Stop sending and let every awaited solution come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_solutions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_alpha(input logic [ulsts_pkg::FIELD_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      alpha_q = value;
   endtask

   // Mix of full-range, near-unity and extreme Q16.16 values.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(4))
         0, 1: return $urandom;
         2, 3: return $urandom_range(262143) - 131072;
         default: begin
            case ($urandom_range(4))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hffff_ffff;
            endcase
         end
      endcase
   endfunction

   // Build one item of a row; lower entries only ever name solved rows.
   function automatic ulsts_pkg::req_type make_entry(
      input logic [ulsts_pkg::ROW_BITS-1:0] row, input logic last);
      ulsts_pkg::req_type item;
      int                 kind;
      int                 pick;
      item.row_index   = row;
      item.col_index   = ulsts_pkg::ROW_BITS'($urandom_range(LAST_ROW));
      item.entry_value = pick_value();
      item.has_entry   = 1'b1;
      item.rhs_value   = pick_value();
      item.row_end     = last;
      kind = $urandom_range(9);
      if (kind <= 6) begin
         item.col_index = row;
         if (last_solved >= 0 && last_solved < row && $urandom_range(1) == 0) begin
            item.col_index = ulsts_pkg::ROW_BITS'(last_solved);
         end else if (solved_rows.size() != 0) begin
            for (int t = 0; t < 8; t++) begin
               pick = solved_rows[$urandom_range(solved_rows.size() - 1)];
               if (pick < row) begin
                  item.col_index = ulsts_pkg::ROW_BITS'(pick);
                  break;
               end
            end
         end
      end else if (kind == 7) begin
         item.col_index = row;
      end else if (kind == 8) begin
         item.col_index = ulsts_pkg::ROW_BITS'($urandom_range(LAST_ROW, row));
      end else begin
         item.has_entry = 1'b0;
      end
      return item;
   endfunction

   task automatic send_row(input logic [ulsts_pkg::ROW_BITS-1:0] row);
      int                 extra;
      ulsts_pkg::req_type item;
      extra = $urandom_range(5);
      for (int k = 0; k < extra; k++) send_item(make_entry(row, 1'b0));
      item = make_entry(row, 1'b1);
      if ($urandom_range(3) == 0) item.has_entry = 1'b0;
      send_item(item);
   endtask

   // One well-formed pass: row 0 first, rows ascending with dense or wide steps.
   task automatic send_pass(input int target);
      int row;
      int step;
      step = ($urandom_range(3) == 0) ? 400 : 3;
      row  = 0;
      while (row <= LAST_ROW && sent_count < target) begin
         send_row(ulsts_pkg::ROW_BITS'(row));
         row += $urandom_range(step, 1);
      end
   endtask

   // Rows out of order, a restart in mid-pass, or a row left open into another.
   task automatic send_disorder();
      case ($urandom_range(2))
         0: send_row(ulsts_pkg::ROW_BITS'($urandom_range(LAST_ROW)));
         1: send_row('0);
         default: begin
            send_item(make_entry(ulsts_pkg::ROW_BITS'($urandom_range(LAST_ROW)), 1'b0));
            send_row(ulsts_pkg::ROW_BITS'($urandom_range(LAST_ROW)));
         end
      endcase
   endtask

   // Empty rows, ignored entries, exact rounding and rows at the top of the store.
   task automatic test_special_rows();
      send_fields(0, 0, 32'h0, 1'b0, 32'h7fff_ffff, 1'b1);
      send_fields(2, 2, 32'h7fff_ffff, 1'b1, 32'h0, 1'b0);
      send_fields(2, LAST_ROW, 32'h8000_0000, 1'b1, 32'h0, 1'b0);
      send_fields(2, 0, 32'h0, 1'b0, 32'h0001_0000, 1'b1);
      send_fields(3, 2, 32'h8000_0000, 1'b1, 32'hffff_ffff, 1'b1);
      send_fields(4, 0, 32'h0, 1'b0, 32'hffff_ffff, 1'b1);
      send_fields(5, 4, 32'h0000_0001, 1'b1, 32'h0, 1'b1);
      // A tiny negative difference must round down to minus one.
      send_fields(6, 4, 32'hffff_ffff, 1'b1, 32'h0, 1'b1);
      send_fields(LAST_ROW, 0, 32'h0, 1'b0, 32'h8000_0000, 1'b1);
      send_fields(LAST_ROW - 1, LAST_ROW, 32'h7fff_ffff, 1'b1, 32'h0, 1'b0);
      send_fields(LAST_ROW - 1, 3, 32'h0000_0001, 1'b1, 32'h1234_5678, 1'b1);
      send_fields(0, 0, 32'h7fff_ffff, 1'b1, 32'h0000_3039, 1'b1);
      wait_drained();
   endtask

   // Accumulator overflow, result clamping and subtraction overflow.
   task automatic test_saturation_paths();
      send_fields(0, 0, 32'h0, 1'b0, 32'h7fff_ffff, 1'b1);
      send_fields(1, 0, 32'h7fff_ffff, 1'b1, 32'h0, 1'b0);
      send_fields(1, 0, 32'h7fff_ffff, 1'b1, 32'h0, 1'b0);
      send_fields(1, 0, 32'h7fff_ffff, 1'b1, 32'h8000_0000, 1'b1);
      wait_drained();
      write_alpha(32'h7fff_ffff);
      send_fields(7, 0, 32'h0, 1'b0, 32'h7fff_ffff, 1'b1);
      wait_drained();
      write_alpha(32'h8000_0000);
      send_fields(8, 0, 32'h0, 1'b0, 32'h7fff_ffff, 1'b1);
      send_fields(9, 1, 32'h7fff_ffff, 1'b1, 32'h0, 1'b0);
      send_fields(9, 1, 32'h7fff_ffff, 1'b1, 32'h8000_0000, 1'b1);
      wait_drained();
   endtask

   // Random passes under one alpha and one idling pattern, drained at the start, halfway and at the end.
   task automatic test_random_phase(input int gap_pct, input int hold_pct,
                                    input logic [ulsts_pkg::FIELD_BITS-1:0] alpha);
      bit paused;
      paused = 1'b0;
      wait_drained();
      write_alpha(alpha);
      sender_gap_pct    = gap_pct;
      receiver_hold_pct = hold_pct;
      sent_count        = 0;
      while (sent_count < PHASE_ITEMS) begin
         if ($urandom_range(9) == 0) send_disorder();
         else send_pass(PHASE_ITEMS);
         if (!paused && sent_count >= PHASE_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_gap_pct    = 14;
      receiver_hold_pct = 81;
      test_special_rows();
      test_saturation_paths();
      test_random_phase(14, 81, 32'h0001_0000);
      test_random_phase(14, 81, 32'h7fff_ffff);
      test_random_phase(81, 14, 32'h8000_0000);
      test_random_phase(81, 14, $urandom);
      test_random_phase(0, 0, 32'h0000_0000);
      test_random_phase(0, 0, 32'hffff_0000);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Hard limit in case the block hangs.
   initial begin
      #TIMEOUT_NS;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

@@ unit_lower_sparse_tri_solve_top.f @@
hdl/ulsts_pkg.sv
hdl/ulsts_store.sv
hdl/unit_lower_sparse_tri_solve_top.sv
sim/tb.sv
